// ===== hdl/pab_pkg.sv =====
`default_nettype none

package pab_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned INDEX_W = 16;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    localparam logic [CFG_ADDR_W-1:0] REG_TINT_RED = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TINT_GREEN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TINT_BLUE = 2'd2;

    typedef struct packed {
        logic [INDEX_W-1:0] pixel_index;
        logic [CHAN_W-1:0]  grey_level;
        logic               first_layer;
    } t_in_req;

    typedef struct packed {
        logic [INDEX_W-1:0] out_index;
        logic [CHAN_W-1:0]  out_red;
        logic [CHAN_W-1:0]  out_green;
        logic [CHAN_W-1:0]  out_blue;
    } t_out_req;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

endpackage

`default_nettype wire

// ===== hdl/pab_ram.sv =====
`default_nettype none

module pab_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 65536
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pab_chan_add.sv =====
`default_nettype none

module pab_chan_add (
    input  wire logic [pab_pkg::CHAN_W-1:0] i_stored,
    input  wire logic [pab_pkg::CHAN_W-1:0] i_tint,
    input  wire logic [pab_pkg::CHAN_W-1:0] i_grey,
    output logic      [pab_pkg::CHAN_W-1:0] o_sum
);

    logic [2*pab_pkg::CHAN_W-1:0] prod;
    logic [2*pab_pkg::CHAN_W:0]   biased;
    logic [pab_pkg::CHAN_W-1:0]   scaled;
    logic [pab_pkg::CHAN_W:0]     sum;

    // Exact floor division by 255 for products up to 255 * 255.
    always_comb begin
        prod = {{pab_pkg::CHAN_W{1'b0}}, i_tint} * {{pab_pkg::CHAN_W{1'b0}}, i_grey};
        biased = {1'b0, prod} + 17'(prod[2*pab_pkg::CHAN_W-1:pab_pkg::CHAN_W]) + 17'd1;
        scaled = biased[2*pab_pkg::CHAN_W-1:pab_pkg::CHAN_W];
        sum = {1'b0, i_stored} + {1'b0, scaled};
        o_sum = sum[pab_pkg::CHAN_W] ? pab_pkg::CHAN_MAX : sum[pab_pkg::CHAN_W-1:0];
    end

endmodule

`default_nettype wire

// ===== hdl/pseudocolor_additive_blend_top.sv =====
// Additive pseudocolor blend of grey layers into one RGB tile.
// Software writes the tint of a layer into the three tint registers through
// the write port (index 0 red, 1 green, 2 blue) while the block is idle, then
// streams that layer's grey samples on the input channel. Each request names a
// pixel; its stored RGB (or zero when first_layer is set) gets
// floor(tint * grey / 255) added per channel with saturation at 255, the
// result is written back and returned as one output request.
// Both channels use valid and stall. One request is accepted per cycle unless
// o_in_stall is high; the result is presented when the output register loads
// behind the registered read of the pixel store, and is taken at an edge
// without i_out_stall. Back-to-back requests to the same pixel are forwarded,
// so the sustained rate is one per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds and the block keeps
// accepting until its single internal stage is also full.
// Reset sets all tints to 255 and empties the pipeline; the pixel store is
// not cleared and a pixel must be written with first_layer before it is read.
// Pixel indexes at or beyond TILE_PIXELS leave the store untouched.
`default_nettype none

module pseudocolor_additive_blend_top #(
    parameter int unsigned TILE_PIXELS = 65536
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pab_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [pab_pkg::CHAN_W-1:0]       i_cfg_wdata,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire pab_pkg::t_in_req                 i_in_req,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output pab_pkg::t_out_req                     o_out_req
);

    localparam int unsigned AW = TILE_PIXELS > 1 ? $clog2(TILE_PIXELS) : 1;

    logic [pab_pkg::CHAN_W-1:0] r_tint_red;
    logic [pab_pkg::CHAN_W-1:0] r_tint_green;
    logic [pab_pkg::CHAN_W-1:0] r_tint_blue;

    logic             r_s1_vld;
    pab_pkg::t_in_req r_s1;
    logic             r_fwd_hit;
    pab_pkg::t_rgb    r_fwd_data;
    logic             r_out_vld;
    pab_pkg::t_out_req r_out;

    logic             n_fwd_hit;
    logic             out_free;
    logic             s1_adv;
    logic             in_accept;
    logic             s1_inside;
    logic             in_inside;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [23:0]      ram_q;
    pab_pkg::t_rgb    ram_rgb;
    pab_pkg::t_rgb    stored;
    pab_pkg::t_rgb    updated;
    logic [pab_pkg::CHAN_W-1:0] sum_red;
    logic [pab_pkg::CHAN_W-1:0] sum_green;
    logic [pab_pkg::CHAN_W-1:0] sum_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint_red <= pab_pkg::CHAN_MAX;
            r_tint_green <= pab_pkg::CHAN_MAX;
            r_tint_blue <= pab_pkg::CHAN_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pab_pkg::REG_TINT_RED:   r_tint_red <= i_cfg_wdata;
                pab_pkg::REG_TINT_GREEN: r_tint_green <= i_cfg_wdata;
                pab_pkg::REG_TINT_BLUE:  r_tint_blue <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        out_free = !r_out_vld || !i_out_stall;
        s1_adv = r_s1_vld && out_free;
        o_in_stall = r_s1_vld && !out_free;
        in_accept = i_in_valid && !o_in_stall;
        s1_inside = 32'(r_s1.pixel_index) < TILE_PIXELS;
        in_inside = 32'(i_in_req.pixel_index) < TILE_PIXELS;
        rd_addr = AW'(i_in_req.pixel_index);
        wr_addr = AW'(r_s1.pixel_index);
        n_fwd_hit = s1_adv && s1_inside && in_inside
                    && (r_s1.pixel_index == i_in_req.pixel_index);
        ram_rgb = pab_pkg::t_rgb'(ram_q);
        if (r_s1.first_layer || !s1_inside) begin
            stored = '0;
        end else if (r_fwd_hit) begin
            stored = r_fwd_data;
        end else begin
            stored = ram_rgb;
        end
    end

    pab_ram #(
        .WIDTH(24),
        .DEPTH(TILE_PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s1_adv && s1_inside),
        .i_waddr (wr_addr),
        .i_wdata (updated),
        .i_re    (in_accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    pab_chan_add u_add_red (
        .i_stored (stored.red),
        .i_tint   (r_tint_red),
        .i_grey   (r_s1.grey_level),
        .o_sum    (sum_red)
    );

    pab_chan_add u_add_green (
        .i_stored (stored.green),
        .i_tint   (r_tint_green),
        .i_grey   (r_s1.grey_level),
        .o_sum    (sum_green)
    );

    pab_chan_add u_add_blue (
        .i_stored (stored.blue),
        .i_tint   (r_tint_blue),
        .i_grey   (r_s1.grey_level),
        .o_sum    (sum_blue)
    );

    assign updated = {sum_red, sum_green, sum_blue};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fwd_hit <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_vld <= 1'b1;
                r_fwd_hit <= n_fwd_hit;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
                r_fwd_hit <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (out_free) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_in_req;
            r_fwd_data <= updated;
        end
        if (s1_adv) begin
            r_out.out_index <= r_s1.pixel_index;
            r_out.out_red <= updated.red;
            r_out.out_green <= updated.green;
            r_out.out_blue <= updated.blue;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_req = r_out;

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_vld)
        else $error("accepted request did not enter the internal stage");

    a_fwd_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_s1_vld)
        else $error("forwarding flag set with an empty stage");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_vld)
        else $error("advanced request did not reach the output register");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall && r_s1_vld) |-> !in_accept)
        else $error("request accepted while the pipeline was full");

endmodule

`default_nettype wire
